### rtl/srbc_pkg.sv
`default_nettype none

package srbc_pkg;

	localparam int NUM_REGS          = 6;
	localparam int XLEN              = 64;
	localparam int PROGRAM_DEPTH_DEF = 64;
	localparam int S_TDATA_W         = 80;
	localparam int S_TUSER_W         = 2;
	localparam int M_TDATA_W         = XLEN * (NUM_REGS + 1);
	localparam int M_TUSER_W         = 2;
	localparam int CFG_INDEX_W       = 2;
	localparam int CFG_DATA_W        = 32;

	typedef logic [NUM_REGS-1:0][XLEN-1:0] regs_t;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_STEP    = 2'd1,
		ACT_RESTART = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_HALTED = 2'd1,
		ST_BAD    = 2'd2
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PC_BINDING     = 2'd0,
		CFG_PROGRAM_LENGTH = 2'd1,
		CFG_START_VALUE    = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_ADDR = 4'd0,
		OP_ADDI = 4'd1,
		OP_MULR = 4'd2,
		OP_MULI = 4'd3,
		OP_BANR = 4'd4,
		OP_BANI = 4'd5,
		OP_BORR = 4'd6,
		OP_BORI = 4'd7,
		OP_SETR = 4'd8,
		OP_SETI = 4'd9,
		OP_GTIR = 4'd10,
		OP_GTRI = 4'd11,
		OP_GTRR = 4'd12,
		OP_EQIR = 4'd13,
		OP_EQRI = 4'd14,
		OP_EQRR = 4'd15
	} op_t;

	// One program word.
	typedef struct packed {
		op_t         opcode;
		logic [2:0]  dest;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
	} instr_t;

	// Decode and execute results handed from the ALU to the control logic.
	typedef struct packed {
		logic            bad;
		logic            is_mul;
		logic [XLEN-1:0] va;
		logic [XLEN-1:0] vb;
		logic [XLEN-1:0] res;
	} exec_t;

	function automatic logic a_is_reg(op_t op);
		return op inside {OP_ADDR, OP_ADDI, OP_MULR, OP_MULI, OP_BANR, OP_BANI,
			OP_BORR, OP_BORI, OP_SETR, OP_GTRI, OP_GTRR, OP_EQRI, OP_EQRR};
	endfunction

	function automatic logic b_is_reg(op_t op);
		return op inside {OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR,
			OP_EQIR, OP_EQRR};
	endfunction

endpackage

`default_nettype wire

### rtl/srbc_pstore.sv
`default_nettype none

module srbc_pstore #(
	parameter int PROGRAM_DEPTH = srbc_pkg::PROGRAM_DEPTH_DEF,
	parameter int AW            = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1
) (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire srbc_pkg::instr_t    wr_data,
	input  wire logic                rd_en,
	input  wire logic [AW-1:0]       rd_addr,
	output srbc_pkg::instr_t         rd_data
);

	srbc_pkg::instr_t mem_q [PROGRAM_DEPTH];
	srbc_pkg::instr_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// The read word holds until the next read, so a stalled step keeps it.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### rtl/srbc_alu.sv
`default_nettype none

module srbc_alu (
	input  wire srbc_pkg::instr_t instr,
	input  wire srbc_pkg::regs_t  regs,
	input  wire logic [srbc_pkg::XLEN-1:0] pc,
	input  wire logic [2:0]  bind_idx,
	output srbc_pkg::exec_t  ex
);

	srbc_pkg::regs_t r;
	logic            a_reg;
	logic            b_reg;
	logic            a_big;
	logic            b_big;
	logic [2:0]      a_idx;
	logic [2:0]      b_idx;

	assign a_reg = srbc_pkg::a_is_reg(instr.opcode);
	assign b_reg = srbc_pkg::b_is_reg(instr.opcode);
	assign a_big = instr.operand_a >= 32'(srbc_pkg::NUM_REGS);
	assign b_big = instr.operand_b >= 32'(srbc_pkg::NUM_REGS);
	assign a_idx = instr.operand_a[2:0];
	assign b_idx = instr.operand_b[2:0];

	always_comb begin
		r = regs;
		// The bound register reads as the current program counter.
		if (bind_idx < 3'(srbc_pkg::NUM_REGS)) begin
			r[bind_idx] = pc;
		end

		ex.bad = (instr.dest >= 3'(srbc_pkg::NUM_REGS)) || (a_reg && a_big) ||
			(b_reg && b_big);
		ex.is_mul = (instr.opcode == srbc_pkg::OP_MULR) ||
			(instr.opcode == srbc_pkg::OP_MULI);

		if (a_reg) begin
			ex.va = a_big ? '0 : r[a_idx];
		end else begin
			ex.va = srbc_pkg::XLEN'(instr.operand_a);
		end
		if (b_reg) begin
			ex.vb = b_big ? '0 : r[b_idx];
		end else begin
			ex.vb = srbc_pkg::XLEN'(instr.operand_b);
		end

		case (instr.opcode)
			srbc_pkg::OP_ADDR, srbc_pkg::OP_ADDI: ex.res = ex.va + ex.vb;
			srbc_pkg::OP_BANR, srbc_pkg::OP_BANI: ex.res = ex.va & ex.vb;
			srbc_pkg::OP_BORR, srbc_pkg::OP_BORI: ex.res = ex.va | ex.vb;
			srbc_pkg::OP_SETR, srbc_pkg::OP_SETI: ex.res = ex.va;
			srbc_pkg::OP_GTIR, srbc_pkg::OP_GTRI, srbc_pkg::OP_GTRR:
				ex.res = srbc_pkg::XLEN'($signed(ex.va) > $signed(ex.vb));
			srbc_pkg::OP_EQIR, srbc_pkg::OP_EQRI, srbc_pkg::OP_EQRR:
				ex.res = srbc_pkg::XLEN'(ex.va == ex.vb);
			default: ex.res = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/srbc_mul.sv
`default_nettype none

module srbc_mul (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [srbc_pkg::XLEN-1:0] va,
	input  wire logic [srbc_pkg::XLEN-1:0] vb,
	output logic      [srbc_pkg::XLEN-1:0] product
);

	// Only the low 64 bits of the product are kept, so the high-by-high
	// term drops out and the cross terms need only their low halves.
	logic [63:0] pp_lo_s2;
	logic [31:0] pp_x_s2;
	logic [31:0] cross_ab;
	logic [31:0] cross_ba;

	assign cross_ab = 32'(va[31:0] * vb[63:32]);
	assign cross_ba = 32'(va[63:32] * vb[31:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			pp_lo_s2 <= 64'(va[31:0]) * 64'(vb[31:0]);
			pp_x_s2  <= cross_ab + cross_ba;
		end
	end

	assign product = pp_lo_s2 + {pp_x_s2, 32'd0};

endmodule

`default_nettype wire

### rtl/six_register_ip_bound_cpu.sv
`default_nettype none

// A result is written to the output register as its item leaves stage one, or stage two for
// a multiply, once that register is free. Items are not overlapped: each step reads the program
// store at the program counter, then executes and writes back before the next item is taken.
// Reset (arst_n low) clears the six registers, program counter, halt flag, configuration
// and handshake state at once; the program store is not cleared and must be loaded first.
module six_register_ip_bound_cpu #(
	parameter int PROGRAM_DEPTH = srbc_pkg::PROGRAM_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,

	// Input stream.
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// load_address[5:0], opcode[9:6], operand_a[41:10], operand_b[73:42],
	// operand_c[76:74], zero fill [79:77]
	input  wire logic [srbc_pkg::S_TDATA_W-1:0] s_tdata,
	// action[1:0]
	input  wire logic [srbc_pkg::S_TUSER_W-1:0] s_tuser,

	// Output stream.
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// pc_value[63:0], reg_zero[127:64], reg_one[191:128], reg_two[255:192],
	// reg_three[319:256], reg_four[383:320], reg_five[447:384]
	output logic [srbc_pkg::M_TDATA_W-1:0]      m_tdata,
	// status[1:0]
	output logic [srbc_pkg::M_TUSER_W-1:0]      m_tuser,

	// Configuration write channel.
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [srbc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [srbc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW   = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
	localparam int LW   = (AW > 6) ? AW : 6;
	localparam int LENW = $clog2(PROGRAM_DEPTH + 1);
	localparam int CW   = (LENW > 7) ? LENW : 7;
	localparam int XLEN = srbc_pkg::XLEN;

	// Configuration registers: change only while idle; the block does not enforce it.
	logic [2:0]  pc_binding_q;
	logic [6:0]  prog_len_q;
	logic [31:0] start_value_q;

	// Architectural state. The program itself lives in the program store.
	srbc_pkg::regs_t regs_q;
	logic [XLEN-1:0] pc_q;
	logic            halted_q;

	// Pipeline control. Stage one holds an item while the fetched word is
	// decoded and executed; stage two holds a multiply while its partial products settle.
	logic           valid_s1;
	srbc_pkg::act_t action_s1;
	logic           valid_s2;

	// Output register.
	logic                             out_valid_q;
	logic [srbc_pkg::M_TDATA_W-1:0]   out_data_q;
	srbc_pkg::status_t                out_status_q;

	logic             accept;
	logic             out_free;
	logic             fin;
	logic             to_s2;
	srbc_pkg::act_t   in_action;
	srbc_pkg::instr_t wr_instr;
	srbc_pkg::instr_t rd_instr;
	srbc_pkg::exec_t  ex;
	logic [XLEN-1:0]  product;
	logic [LW-1:0]    load_addr_ext;
	logic             load_in_range;
	logic [CW-1:0]    plen_ext;
	logic [LENW-1:0]  plen;
	logic             bind_ok;
	logic             pc_out;

	srbc_pkg::regs_t   regs_d;
	logic [XLEN-1:0]   pc_d;
	logic              halted_d;
	srbc_pkg::status_t status_d;
	logic              wb;
	logic [XLEN-1:0]   wb_res;
	logic [XLEN-1:0]   next_pc;

	// The configuration port never stalls.
	assign cfg_ready = 1'b1;

	// A new item enters once the previous one has left both stages; a result
	// still waiting in the output register does not hold up the transfer.
	assign s_tready = !valid_s1 && !valid_s2;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign in_action          = srbc_pkg::act_t'(s_tuser[1:0]);
	assign wr_instr.opcode    = srbc_pkg::op_t'(s_tdata[9:6]);
	assign wr_instr.dest      = s_tdata[76:74];
	assign wr_instr.operand_a = s_tdata[41:10];
	assign wr_instr.operand_b = s_tdata[73:42];

	// Loads beyond the store are dropped.
	assign load_addr_ext = LW'(s_tdata[5:0]);
	assign load_in_range = 32'(s_tdata[5:0]) < 32'(PROGRAM_DEPTH);

	srbc_pstore #(
		.PROGRAM_DEPTH(PROGRAM_DEPTH),
		.AW           (AW)
	) u_pstore (
		.clk    (clk),
		.wr_en  (accept && (in_action == srbc_pkg::ACT_LOAD) && load_in_range),
		.wr_addr(load_addr_ext[AW-1:0]),
		.wr_data(wr_instr),
		.rd_en  (accept && (in_action == srbc_pkg::ACT_STEP)),
		.rd_addr(pc_q[AW-1:0]),
		.rd_data(rd_instr)
	);

	// The registers, program counter and fetched word stay put until the
	// step writes back, so the ALU outputs are still good in stage two.
	srbc_alu u_alu (
		.instr   (rd_instr),
		.regs    (regs_q),
		.pc      (pc_q),
		.bind_idx(pc_binding_q),
		.ex      (ex)
	);

	srbc_mul u_mul (
		.clk    (clk),
		.en     (to_s2),
		.va     (ex.va),
		.vb     (ex.vb),
		.product(product)
	);

	// The program is the first min(program_length, depth) words.
	assign plen_ext = CW'(prog_len_q);
	assign plen     = (plen_ext < CW'(PROGRAM_DEPTH)) ? plen_ext[LENW-1:0] :
		LENW'(PROGRAM_DEPTH);
	assign bind_ok  = pc_binding_q < 3'(srbc_pkg::NUM_REGS);
	assign pc_out   = pc_q[XLEN-1] || (pc_q >= XLEN'(plen));

	// Next-state logic for whichever item finishes this cycle.
	always_comb begin
		regs_d   = regs_q;
		pc_d     = pc_q;
		halted_d = halted_q;
		status_d = srbc_pkg::ST_DONE;
		to_s2    = 1'b0;
		wb       = 1'b0;
		wb_res   = ex.res;
		next_pc  = pc_q;

		if (valid_s2) begin
			wb     = 1'b1;
			wb_res = product;
		end else if (valid_s1) begin
			case (action_s1)
				srbc_pkg::ACT_STEP: begin
					if (halted_q) begin
						status_d = srbc_pkg::ST_HALTED;
					end else if (!bind_ok) begin
						status_d = srbc_pkg::ST_BAD;
					end else if (pc_out) begin
						halted_d = 1'b1;
						status_d = srbc_pkg::ST_HALTED;
					end else if (ex.bad) begin
						status_d = srbc_pkg::ST_BAD;
					end else if (ex.is_mul) begin
						to_s2 = 1'b1;
					end else begin
						wb = 1'b1;
					end
				end
				srbc_pkg::ACT_RESTART: begin
					regs_d    = '0;
					regs_d[0] = XLEN'(start_value_q);
					pc_d      = '0;
					halted_d  = 1'b0;
				end
				default: begin
				end
			endcase
		end

		// Write back: the bound register takes the program counter first,
		// then the destination takes the result, which may overwrite it.
		if (wb) begin
			regs_d[pc_binding_q] = pc_q;
			regs_d[rd_instr.dest] = wb_res;
			next_pc = regs_d[pc_binding_q] + XLEN'(1);
			pc_d    = next_pc;
			if (next_pc[XLEN-1] || (next_pc >= XLEN'(plen))) begin
				halted_d = 1'b1;
				status_d = srbc_pkg::ST_HALTED;
			end
		end
	end

	// An item finishes only when the output register can take its result.
	assign fin = (valid_s2 || (valid_s1 && !to_s2)) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_binding_q  <= '0;
			prog_len_q    <= '0;
			start_value_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (srbc_pkg::cfg_idx_t'(cfg_index))
				srbc_pkg::CFG_PC_BINDING:     pc_binding_q  <= cfg_data[2:0];
				srbc_pkg::CFG_PROGRAM_LENGTH: prog_len_q    <= cfg_data[6:0];
				srbc_pkg::CFG_START_VALUE:    start_value_q <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			action_s1 <= srbc_pkg::ACT_LOAD;
			valid_s2  <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1  <= 1'b1;
				action_s1 <= in_action;
			end else if (valid_s1 && (to_s2 || out_free)) begin
				valid_s1 <= 1'b0;
			end
			if (to_s2) begin
				valid_s2 <= 1'b1;
			end else if (out_free) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q      <= '0;
			pc_q        <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (fin) begin
			regs_q      <= regs_d;
			pc_q        <= pc_d;
			halted_q    <= halted_d;
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_data_q   <= {regs_d, pc_d};
			out_status_q <= status_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the six-register machine with a program counter bound to one
// register. Stimulus goes in as stream transfers from a queue that the initial block fills;
// every input transfer is run through a mirror of the machine kept in this file, and every
// output transfer is checked field by field against the oldest prediction still owed.
module tb;
	import srbc_pkg::*;

	localparam int         CYCLE_LIMIT = 1_000_000;
	localparam int         ITEM_TARGET = 1430;
	localparam int         STORE_WORDS = 64;
	// The action code that the block accepts but otherwise ignores.
	localparam logic [1:0] ACT_UNUSED  = 2'd3;

	// One input item before it is packed onto the stream.
	typedef struct {
		logic [1:0]  action;
		logic [5:0]  addr;
		op_t         op;
		logic [31:0] opa;
		logic [31:0] opb;
		logic [2:0]  dst;
	} cmd_t;

	// What one output transfer should carry.
	typedef struct packed {
		status_t     st;
		logic [63:0] pc;
		regs_t       rf;
	} machine_view_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Items waiting to be offered, and predictions waiting for their output transfer.
	cmd_t          cmd_fifo [$];
	machine_view_t due_views [$];

	int  made         = 0;
	int  fails        = 0;
	int  results_seen = 0;
	int  cycles       = 0;
	bit  loaded [STORE_WORDS];

	// Mirror of the machine: registers, program counter, halt flag, program store and
	// the three configuration registers.
	logic [63:0] m_rf [NUM_REGS];
	logic [63:0] m_pc;
	bit          m_halted;
	op_t         m_op  [STORE_WORDS];
	logic [2:0]  m_dst [STORE_WORDS];
	logic [31:0] m_opa [STORE_WORDS];
	logic [31:0] m_opb [STORE_WORDS];
	logic [2:0]  m_bind;
	logic [6:0]  m_len;
	logic [31:0] m_start;

	string reg_label [NUM_REGS] = '{"reg_zero", "reg_one", "reg_two", "reg_three",
		"reg_four", "reg_five"};

	// Handshake pacing: gap counters on both sides, and a shared calm period in which
	// neither side draws a new gap.
	int send_gap  = 0;
	int take_gap  = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit calm      = 1'b0;
	int calm_left = 0;

	six_register_ip_bound_cpu #(
		.PROGRAM_DEPTH(STORE_WORDS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	// Operand a names a register for every form except the immediate-first compares
	// and set-immediate.
	function automatic bit reg_a_used(op_t op);
		case (op)
		OP_SETI, OP_GTIR, OP_EQIR: return 1'b0;
		default: return 1'b1;
		endcase
	endfunction

	// Operand b names a register only for the register-register forms and the
	// immediate-first compares.
	function automatic bit reg_b_used(op_t op);
		case (op)
		OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: return 1'b1;
		default: return 1'b0;
		endcase
	endfunction

	// Runs one input item through the mirror and returns what the block must report.
	function automatic machine_view_t machine_step(logic [1:0] action,
			logic [S_TDATA_W-1:0] d);
		machine_view_t v;
		logic [63:0]   r [NUM_REGS];
		logic [63:0]   lim, va, vb, res, nxt;
		logic [5:0]    at;
		op_t           op;
		logic [2:0]    c;
		logic [31:0]   a, b;
		status_t       st;
		st = ST_DONE;
		case (action)
		ACT_LOAD: begin
			at = d[5:0];
			m_op[at]  = op_t'(d[9:6]);
			m_opa[at] = d[41:10];
			m_opb[at] = d[73:42];
			m_dst[at] = d[76:74];
		end
		ACT_STEP: begin
			lim = (m_len < STORE_WORDS) ? 64'(m_len) : 64'(STORE_WORDS);
			if (m_halted) begin
				st = ST_HALTED;
			end else if (m_bind > 5) begin
				st = ST_BAD;
			end else if (m_pc[63] || m_pc >= lim) begin
				m_halted = 1'b1;
				st = ST_HALTED;
			end else begin
				op = m_op[m_pc[5:0]];
				c  = m_dst[m_pc[5:0]];
				a  = m_opa[m_pc[5:0]];
				b  = m_opb[m_pc[5:0]];
				if (c > 5 || (reg_a_used(op) && a > 5) || (reg_b_used(op) && b > 5)) begin
					st = ST_BAD;
				end else begin
					// The bound register sees the program counter before the instruction.
					r = m_rf;
					r[m_bind] = m_pc;
					va = reg_a_used(op) ? r[a[2:0]] : 64'(a);
					vb = reg_b_used(op) ? r[b[2:0]] : 64'(b);
					case (op)
					OP_ADDR, OP_ADDI: res = va + vb;
					OP_MULR, OP_MULI: res = va * vb;
					OP_BANR, OP_BANI: res = va & vb;
					OP_BORR, OP_BORI: res = va | vb;
					OP_SETR, OP_SETI: res = va;
					OP_GTIR, OP_GTRI, OP_GTRR: res = ($signed(va) > $signed(vb)) ? 64'd1 : 64'd0;
					default: res = (va == vb) ? 64'd1 : 64'd0;
					endcase
					r[c] = res;
					m_rf = r;
					nxt = r[m_bind] + 64'd1;
					m_pc = nxt;
					// A jump that leaves the program still commits, then halts.
					if (nxt[63] || nxt >= lim) begin
						m_halted = 1'b1;
						st = ST_HALTED;
					end
				end
			end
		end
		ACT_RESTART: begin
			for (int i = 0; i < NUM_REGS; i++)
				m_rf[i] = '0;
			m_rf[0] = 64'(m_start);
			m_pc = '0;
			m_halted = 1'b0;
		end
		default: ;
		endcase
		v.st = st;
		v.pc = m_pc;
		for (int i = 0; i < NUM_REGS; i++)
			v.rf[i] = m_rf[i];
		return v;
	endfunction

	// Most gaps are short or absent; a few are long.
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Immediates lean toward small values so that jumps stay inside short programs.
	function automatic logic [31:0] pick_imm();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom_range(0, 8);
		if (r < 70)
			return $urandom_range(0, 64);
		if (r < 85)
			return $urandom;
		if (r < 92)
			return 32'd0;
		return 32'hFFFF_FFFF;
	endfunction

	// An item whose data fields are random; the action alone decides what it does.
	function automatic cmd_t loose_cmd(logic [1:0] action);
		cmd_t x;
		x.action = action;
		x.addr   = 6'($urandom);
		x.op     = op_t'($urandom_range(0, 15));
		x.opa    = $urandom;
		x.opb    = $urandom;
		x.dst    = 3'($urandom);
		return x;
	endfunction

	task automatic send(cmd_t x);
		if (x.action == ACT_LOAD)
			loaded[x.addr] = 1'b1;
		cmd_fifo.insert(cmd_fifo.size(), x);
		made++;
	endtask

	task automatic send_word(int addr, op_t op, logic [31:0] a, logic [31:0] b,
			logic [2:0] c);
		cmd_t x;
		x.action = ACT_LOAD;
		x.addr   = 6'(addr);
		x.op     = op;
		x.opa    = a;
		x.opb    = b;
		x.dst    = c;
		send(x);
	endtask

	// Loads a random program word. A clean word names only existing registers and now and
	// then writes the bound register, which makes the program jump.
	task automatic load_word(int addr, int binding, bit clean);
		cmd_t x;
		int   home;
		x = loose_cmd(ACT_LOAD);
		x.addr = 6'(addr);
		home = (binding > 5) ? 0 : binding;
		if (clean) begin
			x.dst = ($urandom_range(0, 99) < 12) ? 3'(home) : 3'($urandom_range(0, 5));
			x.opa = reg_a_used(x.op) ? 32'($urandom_range(0, 5)) : pick_imm();
			x.opb = reg_b_used(x.op) ? 32'($urandom_range(0, 5)) : pick_imm();
		end
		send(x);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Sampled on the falling edge so that the queues and valid have settled.
	task automatic wait_idle();
		do @(negedge clk); while (cmd_fifo.size() != 0 || s_tvalid || due_views.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Calm periods come and go so that some stretches run with no gaps drawn on either side.
	always @(posedge clk) begin
		if (calm_left == 0) begin
			calm <= !calm;
			calm_left <= $urandom_range(50, 300);
		end else begin
			calm_left <= calm_left - 1;
		end
	end

	// Input driver. A new item is put up only once the previous transfer has happened,
	// so valid stays high across back-to-back items without being dropped in between.
	always @(posedge clk) begin : feed
		cmd_t head;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (cmd_fifo.size() != 0) begin
				head = cmd_fifo.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= head.action;
				s_tdata  <= {3'b000, head.dst, head.opb, head.opa, head.op, head.addr};
				send_gap <= calm ? 0 : draw_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output ready. Once, while the sender still has a backlog, ready is held low for a
	// long stretch so that the block fills up and has to stall its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			take_gap <= 0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= 150 && cmd_fifo.size() > 4) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else if (take_gap > 0) begin
			m_tready <= 1'b0;
			take_gap <= take_gap - 1;
		end else begin
			m_tready <= 1'b1;
			if (m_tvalid && m_tready)
				take_gap <= calm ? 0 : draw_gap();
		end
	end

	// Monitor and checker. An output transfer is compared before the input transfer of the
	// same edge is predicted; a result never leaves in the cycle its item arrives.
	always @(posedge clk) begin : watch
		machine_view_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				m_rf[i] = '0;
			m_pc = '0;
			m_halted = 1'b0;
			m_bind = '0;
			m_len = '0;
			m_start = '0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (due_views.size() == 0) begin
					$error("result transfer with no prediction waiting");
					fails++;
				end else begin
					want = due_views.pop_front();
					if (m_tuser !== want.st) begin
						$error("status: expected %0d, actual %0d", want.st, m_tuser);
						fails++;
					end
					if (m_tdata[63:0] !== want.pc) begin
						$error("pc_value: expected %h, actual %h", want.pc, m_tdata[63:0]);
						fails++;
					end
					for (int i = 0; i < NUM_REGS; i++) begin
						if (m_tdata[64 + 64 * i +: 64] !== want.rf[i]) begin
							$error("%s: expected %h, actual %h", reg_label[i], want.rf[i],
								m_tdata[64 + 64 * i +: 64]);
							fails++;
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_PC_BINDING:     m_bind  = cfg_data[2:0];
				CFG_PROGRAM_LENGTH: m_len   = cfg_data[6:0];
				CFG_START_VALUE:    m_start = cfg_data;
				default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				due_views.insert(due_views.size(), machine_step(s_tuser, s_tdata));
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("six_register_ip_bound_cpu verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int          len, binding, steps, pick;
		logic [31:0] start;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Straight out of reset the program is empty: a step halts, a second step finds
		// the machine halted, the unused action reports done, and a restart clears it.
		send(loose_cmd(ACT_STEP));
		send(loose_cmd(ACT_STEP));
		send(loose_cmd(ACT_UNUSED));
		send(loose_cmd(ACT_RESTART));

		// A short program that walks through full-width values. Set-immediate carries an
		// all-ones b that must not be checked as a register; the second multiply wraps; the
		// logic operations use all 64 bits; the greater-than sees a negative operand.
		// The last word names a register that does not exist.
		send_word(0, OP_SETI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd1);
		send_word(1, OP_MULI, 32'd1, 32'hFFFF_FFFF, 3'd2);
		send_word(2, OP_MULR, 32'd2, 32'd2, 3'd3);
		send_word(3, OP_BORR, 32'd2, 32'd1, 3'd4);
		send_word(4, OP_BANI, 32'd4, 32'hFFFF_FFFF, 3'd4);
		send_word(5, OP_GTRR, 32'd3, 32'd2, 3'd0);
		send_word(6, OP_EQRR, 32'd1, 32'd1, 3'd3);
		send_word(7, OP_ADDR, 32'd6, 32'd0, 3'd0);
		wait_idle();

		// Bind the program counter to the highest register and start r0 at the zero-extended value FFFF_FFFF.
		write_reg(CFG_PC_BINDING, 32'd5);
		write_reg(CFG_PROGRAM_LENGTH, 32'd8);
		write_reg(CFG_START_VALUE, 32'hFFFF_FFFF);
		send(loose_cmd(ACT_RESTART));
		repeat (8)
			send(loose_cmd(ACT_STEP));
		// Replace the bad word with a jump far past the end: the step commits and halts,
		// and the step after it finds the machine halted.
		send_word(7, OP_ADDI, 32'd5, 32'd100, 3'd5);
		send(loose_cmd(ACT_STEP));
		send(loose_cmd(ACT_STEP));
		wait_idle();

		// A binding beyond the register file refuses to step.
		write_reg(CFG_PC_BINDING, 32'd7);
		send(loose_cmd(ACT_RESTART));
		send(loose_cmd(ACT_STEP));

		// Random sessions: new settings, a freshly loaded program, a restart, then mostly
		// steps with some reloads, broken words, restarts and unused actions mixed in.
		while (made < ITEM_TARGET) begin
			wait_idle();
			pick = $urandom_range(0, 99);
			binding = (pick < 4) ? $urandom_range(6, 7) : $urandom_range(0, 5);
			pick = $urandom_range(0, 99);
			len = (pick < 8) ? STORE_WORDS : (pick < 13) ? 0 : $urandom_range(1, 12);
			pick = $urandom_range(0, 99);
			if (pick < 15)
				start = 32'd0;
			else if (pick < 30)
				start = 32'hFFFF_FFFF;
			else if (pick < 50)
				start = $urandom_range(0, 20);
			else
				start = $urandom;
			write_reg(CFG_PC_BINDING, 32'(binding));
			write_reg(CFG_PROGRAM_LENGTH, 32'(len));
			write_reg(CFG_START_VALUE, start);

			// Every word inside the program is loaded before any step can fetch it.
			for (int k = 0; k < len; k++)
				if (!loaded[k] || $urandom_range(0, 3) != 0)
					load_word(k, binding, $urandom_range(0, 99) >= 3);
			send(loose_cmd(ACT_RESTART));

			steps = $urandom_range(4, 40);
			repeat (steps) begin
				pick = $urandom_range(0, 99);
				if (pick < 84)
					send(loose_cmd(ACT_STEP));
				else if (pick < 90)
					load_word($urandom_range(0, STORE_WORDS - 1), binding, 1'b1);
				else if (pick < 93)
					load_word($urandom_range(0, STORE_WORDS - 1), binding, 1'b0);
				else if (pick < 97)
					send(loose_cmd(ACT_RESTART));
				else
					send(loose_cmd(ACT_UNUSED));
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("six_register_ip_bound_cpu verification clean");
		else
			$display("six_register_ip_bound_cpu verification failed");
		$finish;
	end

endmodule
